// ===== rtl/core/tilp_pkg.sv =====
`timescale 1ns / 1ps

package tilp_pkg;

	localparam int MAG_W = 64;
	localparam int ACC_W = MAG_W + 4;
	localparam int LEN_W = 16;
	localparam logic [LEN_W-1:0] LEN_CAP = '1;
	localparam logic [ACC_W-1:0] TOP_BIT = ACC_W'(1) << (MAG_W - 1);

	typedef enum logic [1:0] {
		MODE_DEC = 2'd0,
		MODE_HEX = 2'd1,
		MODE_OCT = 2'd2,
		MODE_BIN = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNDERSCORE = 3'd1,
		ST_LEAD_ZERO  = 3'd2,
		ST_RANGE      = 3'd3,
		ST_NO_DIGITS  = 3'd4
	} status_t;

	// Character class as seen by the back end
	typedef struct packed {
		logic       last;
		logic       is_digit;
		logic [3:0] dval;
		logic       is_us;
		logic       is_plus;
		logic       is_minus;
		logic       is_pfx;
		mode_t      pfx_mode;
	} chr_t;

	function automatic chr_t classify(input logic [7:0] c, input logic lst);
		chr_t r;
		r          = '0;
		r.last     = lst;
		r.pfx_mode = MODE_DEC;
		if (c >= "0" && c <= "9") begin
			r.is_digit = 1'b1;
			r.dval     = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			r.is_digit = 1'b1;
			r.dval     = 4'(c - "A" + 8'd10);
		end else if (c >= "a" && c <= "f") begin
			r.is_digit = 1'b1;
			r.dval     = 4'(c - "a" + 8'd10);
		end
		r.is_us    = (c == "_");
		r.is_plus  = (c == "+");
		r.is_minus = (c == "-");
		case (c)
			"x": begin
				r.is_pfx   = 1'b1;
				r.pfx_mode = MODE_HEX;
			end
			"o": begin
				r.is_pfx   = 1'b1;
				r.pfx_mode = MODE_OCT;
			end
			"b": begin
				r.is_pfx   = 1'b1;
				r.pfx_mode = MODE_BIN;
			end
			default: begin
				r.is_pfx   = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/tilp_if.sv =====
`timescale 1ns / 1ps

interface tilp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface tilp_num_if;
	logic                        valid;
	logic                        ready;
	logic signed [63:0]          value;
	logic [15:0]                 num_length;
	logic [2:0]                  status;
	logic                        was_radix;

	modport source (output valid, output value, output num_length, output status,
		output was_radix, input ready);
	modport sink (input valid, input value, input num_length, input status,
		input was_radix, output ready);
endinterface

// ===== rtl/core/tilp_front.sv =====
`timescale 1ns / 1ps

module tilp_front (
	input  logic             clk,
	input  logic             arst_n,
	tilp_char_if.sink        token,
	output logic             push,
	output tilp_pkg::chr_t   push_data,
	input  logic             q_ready
);

	logic            v_s1;
	tilp_pkg::chr_t  chr_s1;

	assign token.ready = !v_s1 || q_ready;
	assign push        = v_s1 && q_ready;
	assign push_data   = chr_s1;

	// Hold the valid flag of the classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (token.ready) begin
			v_s1 <= token.valid;
		end
	end

	// Classify each accepted word
	always_ff @(posedge clk) begin
		if (token.valid && token.ready) begin
			chr_s1 <= tilp_pkg::classify(token.ch, token.last);
		end
	end

endmodule

// ===== rtl/core/tilp_queue.sv =====
`timescale 1ns / 1ps

module tilp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tilp_pkg::chr_t   push_data,
	output logic             q_ready,
	input  logic             pop,
	output logic             q_valid,
	output tilp_pkg::chr_t   pop_data
);

	tilp_pkg::chr_t  mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign q_ready  = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/tilp_back.sv =====
`timescale 1ns / 1ps

module tilp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tilp_pkg::chr_t   pop_data,
	output logic             pop,
	tilp_num_if.source       number
);

	// Token state
	logic [15:0]      pos_q;
	logic             ended_q;
	tilp_pkg::mode_t  mode_q;
	logic             neg_q;
	logic [63:0]      mag_q;
	logic [15:0]      dcnt_q;
	logic             pus_q;
	logic             err_us_q;
	logic             err_ovf_q;
	logic             err_lead_q;
	logic             fz_q;
	logic             ls_q;

	// Next values
	logic [15:0]      pos_n;
	logic             ended_n;
	tilp_pkg::mode_t  mode_n;
	logic             neg_n;
	logic [63:0]      mag_n;
	logic [15:0]      dcnt_n;
	logic             pus_n;
	logic             err_us_n;
	logic             err_ovf_n;
	logic             err_lead_n;
	logic             fz_n;
	logic             ls_n;

	logic             counted;
	logic             digit_ok;
	logic             take_digit;
	logic [67:0]      acc;
	tilp_pkg::chr_t   c;

	// Finish stage
	logic             fin_v_s2;
	logic [63:0]      mag_s2;
	logic [15:0]      pos_s2;
	logic             dec_s2;
	logic             neg_s2;
	logic             us_s2;
	logic             lz_s2;
	logic             lead_s2;
	logic             ovf_s2;
	logic             nod_s2;

	logic             out_v_q;
	logic             out_load;
	logic             fin_free;
	tilp_pkg::status_t st;

	assign c        = pop_data;
	assign out_load = fin_v_s2 && (!out_v_q || number.ready);
	assign fin_free = !fin_v_s2 || out_load;
	assign pop      = q_valid && (!c.last || fin_free);

	// Check the digit against the current radix
	always_comb begin
		case (mode_q)
			tilp_pkg::MODE_DEC: digit_ok = c.is_digit && (c.dval < 4'd10);
			tilp_pkg::MODE_HEX: digit_ok = c.is_digit;
			tilp_pkg::MODE_OCT: digit_ok = c.is_digit && (c.dval < 4'd8);
			tilp_pkg::MODE_BIN: digit_ok = c.is_digit && (c.dval < 4'd2);
			default:            digit_ok = 1'b0;
		endcase
	end

	// Multiply the magnitude by the base and add the digit
	always_comb begin
		case (mode_q)
			tilp_pkg::MODE_DEC: acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
				+ {64'd0, c.dval};
			tilp_pkg::MODE_HEX: acc = {mag_q, 4'b0000} + {64'd0, c.dval};
			tilp_pkg::MODE_OCT: acc = {1'b0, mag_q, 3'b000} + {64'd0, c.dval};
			tilp_pkg::MODE_BIN: acc = {3'b000, mag_q, 1'b0} + {64'd0, c.dval};
			default:            acc = '0;
		endcase
	end

	// Update token state for one word
	always_comb begin
		pos_n      = pos_q;
		ended_n    = ended_q;
		mode_n     = mode_q;
		neg_n      = neg_q;
		mag_n      = mag_q;
		dcnt_n     = dcnt_q;
		pus_n      = pus_q;
		err_us_n   = err_us_q;
		err_ovf_n  = err_ovf_q;
		err_lead_n = err_lead_q;
		fz_n       = fz_q;
		ls_n       = ls_q;
		counted    = 1'b0;
		take_digit = 1'b0;
		if (!ended_q) begin
			counted = 1'b1;
			if (pos_q == 16'd0) begin
				if (c.is_plus || c.is_minus) begin
					ls_n  = 1'b1;
					neg_n = c.is_minus;
				end else if (digit_ok) begin
					take_digit = 1'b1;
				end else if (c.is_us) begin
					err_us_n = 1'b1;
					pus_n    = 1'b1;
				end else begin
					err_lead_n = 1'b1;
				end
			end else if (mode_q == tilp_pkg::MODE_DEC && pos_q == 16'd1 && fz_q
				&& dcnt_q == 16'd1 && !ls_q && c.is_pfx) begin
				mode_n = c.pfx_mode;
				mag_n  = '0;
				dcnt_n = '0;
				fz_n   = 1'b0;
			end else if (digit_ok) begin
				take_digit = 1'b1;
				pus_n      = 1'b0;
			end else if (c.is_us) begin
				if (pus_q || (mode_q == tilp_pkg::MODE_DEC && pos_q == 16'd1 && ls_q)
					|| (mode_q != tilp_pkg::MODE_DEC && pos_q == 16'd2)) begin
					err_us_n = 1'b1;
				end
				pus_n = 1'b1;
			end else begin
				ended_n = 1'b1;
				counted = 1'b0;
			end
			if (take_digit) begin
				if (dcnt_q == 16'd0) begin
					fz_n = (c.dval == 4'd0);
				end
				if (dcnt_q != tilp_pkg::LEN_CAP) begin
					dcnt_n = dcnt_q + 16'd1;
				end
				if (!err_ovf_q) begin
					if (acc > tilp_pkg::TOP_BIT) begin
						err_ovf_n = 1'b1;
					end else begin
						mag_n = acc[63:0];
					end
				end
			end
			if (counted && pos_q != tilp_pkg::LEN_CAP) begin
				pos_n = pos_q + 16'd1;
			end
		end
	end

	// Hold token state; drop it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ended_q    <= 1'b0;
			mode_q     <= tilp_pkg::MODE_DEC;
			neg_q      <= 1'b0;
			mag_q      <= '0;
			dcnt_q     <= '0;
			pus_q      <= 1'b0;
			err_us_q   <= 1'b0;
			err_ovf_q  <= 1'b0;
			err_lead_q <= 1'b0;
			fz_q       <= 1'b0;
			ls_q       <= 1'b0;
		end else if (pop) begin
			if (c.last) begin
				pos_q      <= '0;
				ended_q    <= 1'b0;
				mode_q     <= tilp_pkg::MODE_DEC;
				neg_q      <= 1'b0;
				mag_q      <= '0;
				dcnt_q     <= '0;
				pus_q      <= 1'b0;
				err_us_q   <= 1'b0;
				err_ovf_q  <= 1'b0;
				err_lead_q <= 1'b0;
				fz_q       <= 1'b0;
				ls_q       <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				ended_q    <= ended_n;
				mode_q     <= mode_n;
				neg_q      <= neg_n;
				mag_q      <= mag_n;
				dcnt_q     <= dcnt_n;
				pus_q      <= pus_n;
				err_us_q   <= err_us_n;
				err_ovf_q  <= err_ovf_n;
				err_lead_q <= err_lead_n;
				fz_q       <= fz_n;
				ls_q       <= ls_n;
			end
		end
	end

	// Finish stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s2 <= 1'b0;
		end else if (fin_free) begin
			fin_v_s2 <= pop && c.last;
		end
	end

	// Capture the closing snapshot of a token
	always_ff @(posedge clk) begin
		if (pop && c.last) begin
			mag_s2  <= mag_n;
			pos_s2  <= pos_n;
			dec_s2  <= (mode_n == tilp_pkg::MODE_DEC);
			neg_s2  <= neg_n;
			us_s2   <= err_us_n || pus_n;
			lz_s2   <= (mode_n == tilp_pkg::MODE_DEC) && fz_n && (dcnt_n >= 16'd2);
			lead_s2 <= err_lead_n;
			ovf_s2  <= err_ovf_n;
			nod_s2  <= (dcnt_n == 16'd0);
		end
	end

	// Pick the status in priority order
	always_comb begin
		if (us_s2) begin
			st = tilp_pkg::ST_UNDERSCORE;
		end else if (lz_s2) begin
			st = tilp_pkg::ST_LEAD_ZERO;
		end else if (lead_s2) begin
			st = tilp_pkg::ST_NO_DIGITS;
		end else if (ovf_s2 || (mag_s2[63] && !(dec_s2 && neg_s2))) begin
			st = tilp_pkg::ST_RANGE;
		end else if (nod_s2) begin
			st = tilp_pkg::ST_NO_DIGITS;
		end else begin
			st = tilp_pkg::ST_OK;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (number.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (st != tilp_pkg::ST_OK) begin
				number.value <= '0;
			end else if (dec_s2 && neg_s2) begin
				number.value <= -$signed(mag_s2);
			end else begin
				number.value <= $signed(mag_s2);
			end
			number.num_length <= pos_s2;
			number.status     <= st;
			number.was_radix  <= !dec_s2;
		end
	end

	assign number.valid = out_v_q;

endmodule

// ===== rtl/core/toml_integer_literal_parser.sv =====
`timescale 1ns / 1ps

// Path: last word -> classify register -> queue -> finish stage -> output register.
// Throughput: one character per cycle unless stalled by back-pressure; the token state
// update (constant-base multiply-add and overflow compare) is combinational per character.
// Reset: arst_n clears all control and token state at once; no clearing pass.
// A two-entry queue decouples character classification from the token state.
module toml_integer_literal_parser (
	input  logic        clk,
	input  logic        arst_n,
	tilp_char_if.sink   token,
	tilp_num_if.source  number
);

	logic            push;
	tilp_pkg::chr_t  push_data;
	logic            q_ready;
	logic            pop;
	logic            q_valid;
	tilp_pkg::chr_t  pop_data;

	tilp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.token     (token),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready)
	);

	tilp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_data  (pop_data)
	);

	tilp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.pop_data (pop_data),
		.pop      (pop),
		.number   (number)
	);

endmodule
